@@ hdl/smpq_pkg.sv @@
// Shared types and constants for the sorted min-priority queue.
// Used by the channel interfaces, the queue cell and the top level.
// No dependencies.
package smpq_pkg;

  // Number of cells in the chain (2 to 31, the most the 5-bit count field holds)
  localparam int DEPTH = 16;
  // Internal fill counter width, able to hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width of the reported count field
  localparam int COUNT_W = 5;
  localparam int VALUE_W = 32;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Value reported when nothing was removed or the queue is empty
  localparam logic signed [VALUE_W-1:0] NONE_VALUE = '1;

  // Operation broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      gt;     // valid and stored value > key
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

  // Next-cycle contents of a cell
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } cell_entry_t;

endpackage

@@ hdl/smpq_in_if.sv @@
// Request channel of the priority queue: opcode and value.
// Depends on smpq_pkg.
interface smpq_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     opcode;
  logic signed [smpq_pkg::VALUE_W-1:0]      value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

@@ hdl/smpq_out_if.sv @@
// Response channel of the priority queue: removed value, top, count, status.
// Depends on smpq_pkg.
interface smpq_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [smpq_pkg::VALUE_W-1:0]      removed_value;
  logic signed [smpq_pkg::VALUE_W-1:0]      top_value;
  logic        [smpq_pkg::COUNT_W-1:0]      count;
  logic        [1:0]                        status;

  modport source (output valid, removed_value, top_value, count, status, input ready);
  modport sink   (input valid, removed_value, top_value, count, status, output ready);
endinterface

@@ hdl/smpq_cell.sv @@
// One cell of the sorted queue chain: holds one value and its valid bit.
// Decides its next contents from the key and its two neighbors.
// Depends on smpq_pkg.
module smpq_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smpq_pkg::cell_cmd_t                  cmd,
  input  logic signed [smpq_pkg::VALUE_W-1:0]  key,
  input  smpq_pkg::cell_link_t                 left,
  input  smpq_pkg::cell_link_t                 right,
  output smpq_pkg::cell_link_t                 link,
  output smpq_pkg::cell_entry_t                nxt
);

  logic                                valid;
  logic signed [smpq_pkg::VALUE_W-1:0] value;
  logic                                valid_next;
  logic signed [smpq_pkg::VALUE_W-1:0] value_next;
  logic                                take;

  // Compare against the key; equal values stay ahead of the new one
  assign link.valid = valid;
  assign link.gt    = valid && (value > key);
  assign link.value = value;

  // Push: an occupied cell above the key, or the first free cell, takes
  // either the left neighbor's value (shift up) or the key itself.
  // Pop: every cell takes its right neighbor.
  always_comb begin
    valid_next = valid;
    value_next = value;
    take       = valid ? link.gt : left.valid;
    if (cmd.pop) begin
      valid_next = right.valid;
      value_next = right.value;
    end else if (cmd.push && take) begin
      valid_next = 1'b1;
      value_next = left.gt ? left.value : key;
    end
  end

  assign nxt.valid = valid_next;
  assign nxt.value = value_next;

  // Valid bit is control, value is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ hdl/sorted_min_priority_queue.sv @@
// Top level of the sorted min-priority queue: a chain of smpq_cell instances,
// a fill counter and a registered response stage.
// Depends on smpq_pkg, smpq_in_if, smpq_out_if and smpq_cell.
//
//   channel  direction  payload                                   transfer
//   -------  ---------  ----------------------------------------  ------------------
//   req      in         opcode, value                             valid && ready
//   rsp      out        removed_value, top_value, count, status   valid && ready
//
// One request per cycle while req.ready is high; the response shows in the cycle after its request.
// All cells update together: each compares the key with its own value and takes
// a neighbor's value or the key, so the chain length does not set the rate.
// req.ready drops only while a response waits and rsp.ready is low.
// Synchronous reset empties the queue at once; no clearing pass.
module sorted_min_priority_queue (
  input  logic        clk,
  input  logic        rst,
  smpq_in_if.sink     req,
  smpq_out_if.source  rsp
);

  smpq_pkg::cell_cmd_t   cmd;
  smpq_pkg::cell_link_t  links [smpq_pkg::DEPTH];
  smpq_pkg::cell_link_t  lefts [smpq_pkg::DEPTH];
  smpq_pkg::cell_link_t  rights[smpq_pkg::DEPTH];
  smpq_pkg::cell_entry_t nexts [smpq_pkg::DEPTH];

  logic                                 accept;
  logic                                 empty;
  logic                                 full;
  logic [smpq_pkg::CNT_W-1:0]           cnt;
  logic [smpq_pkg::CNT_W-1:0]           cnt_next;

  logic                                 rsp_valid;
  logic signed [smpq_pkg::VALUE_W-1:0]  removed_value;
  logic signed [smpq_pkg::VALUE_W-1:0]  top_value;
  logic [smpq_pkg::COUNT_W-1:0]         count;
  logic [1:0]                           status;
  logic signed [smpq_pkg::VALUE_W-1:0]  removed_value_next;
  logic signed [smpq_pkg::VALUE_W-1:0]  top_value_next;
  logic [1:0]                           status_next;

  // Response register frees up when it is empty or being taken
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign empty = !links[0].valid;
  assign full  = links[smpq_pkg::DEPTH-1].valid;

  // Broadcast command; dropped operations leave the chain alone
  assign cmd.push = accept && (req.opcode == smpq_pkg::OP_PUSH) && !full;
  assign cmd.pop  = accept && (req.opcode == smpq_pkg::OP_POP) && !empty;

  // Chain ends: the head sees an occupied left neighbor not above the key, the tail shifts in nothing
  generate
    for (genvar i = 0; i < smpq_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign lefts[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
      end else begin : g_mid_l
        assign lefts[i] = links[i-1];
      end
      if (i == smpq_pkg::DEPTH - 1) begin : g_tail
        assign rights[i] = '{valid: 1'b0, gt: 1'b0, value: '0};
      end else begin : g_mid_r
        assign rights[i] = links[i+1];
      end

      smpq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .cmd   (cmd),
        .key   (req.value),
        .left  (lefts[i]),
        .right (rights[i]),
        .link  (links[i]),
        .nxt   (nexts[i])
      );
    end
  endgenerate

  // Fill count and response fields
  always_comb begin
    cnt_next           = cnt;
    removed_value_next = smpq_pkg::NONE_VALUE;
    status_next        = smpq_pkg::ST_OK;
    if (req.opcode == smpq_pkg::OP_PUSH) begin
      if (full) begin
        status_next = smpq_pkg::ST_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = smpq_pkg::ST_EMPTY;
      end else begin
        removed_value_next = links[0].value;
        cnt_next           = cnt - 1'b1;
      end
    end
    top_value_next = nexts[0].valid ? nexts[0].value : smpq_pkg::NONE_VALUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_value_next;
      top_value     <= top_value_next;
      count         <= smpq_pkg::COUNT_W'(cnt_next);
      status        <= status_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.removed_value = removed_value;
  assign rsp.top_value     = top_value;
  assign rsp.count         = count;
  assign rsp.status        = status;

endmodule
